// ===== rtl/dhfk_pkg.sv =====
package dhfk_pkg;

  localparam int NumJoints = 6;
  localparam int RotW      = 18;
  localparam int PosW      = 20;
  localparam int LenW      = 12;
  localparam int AngW      = 16;
  localparam int AccW      = 40;   // position accumulator, mm * 65536
  localparam int CfgIdxW   = 3;

  typedef logic signed [RotW-1:0] rot_ent_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef logic signed [AngW-1:0] ang_t;
  typedef logic        [LenW-1:0] len_t;

  typedef enum logic [1:0] {
    TW_ZERO  = 2'd0,
    TW_POS90 = 2'd1,
    TW_NEG90 = 2'd2
  } twist_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_HEIGHT      = 3'd0,
    CFG_UPPER_ARM_LENGTH = 3'd1,
    CFG_FOREARM_OFFSET   = 3'd2,
    CFG_WRIST_OFFSET     = 3'd3,
    CFG_TOOL_LENGTH      = 3'd4
  } cfg_idx_t;

  // twist of each joint link
  function automatic twist_t link_twist(input int k);
    twist_t tw;
    case (k)
      1, 3, 5: tw = TW_POS90;
      4:       tw = TW_NEG90;
      default: tw = TW_ZERO;
    endcase
    return tw;
  endfunction

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [32:0] atan_val(input int i);
    logic signed [32:0] v;
    case (i)
      0:  v = 33'sh020000000;
      1:  v = 33'sh012E4051E;
      2:  v = 33'sh009FB385B;
      3:  v = 33'sh0051111D4;
      4:  v = 33'sh0028B0D43;
      5:  v = 33'sh00145D7E1;
      6:  v = 33'sh000A2F61E;
      7:  v = 33'sh000517C55;
      8:  v = 33'sh00028BE53;
      9:  v = 33'sh000145F2F;
      10: v = 33'sh0000A2F98;
      11: v = 33'sh0000517CC;
      12: v = 33'sh000028BE6;
      13: v = 33'sh0000145F3;
      14: v = 33'sh00000A2FA;
      15: v = 33'sh00000517D;
      16: v = 33'sh0000028BE;
      17: v = 33'sh00000145F;
      18: v = 33'sh000000A30;
      19: v = 33'sh000000518;
      20: v = 33'sh00000028C;
      21: v = 33'sh000000146;
      22: v = 33'sh0000000A3;
      23: v = 33'sh000000051;
      default: v = 33'sh0;
    endcase
    return v;
  endfunction

  // clamp a rotation entry to [-1, 1] in Q1.16
  function automatic rot_ent_t sat_rot(input acc_t v);
    rot_ent_t r;
    if (v > 40'sd65536) begin
      r = 18'sd65536;
    end else if (v < -40'sd65536) begin
      r = -18'sd65536;
    end else begin
      r = v[RotW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/dhfk_in_if.sv =====
interface dhfk_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  joint1_angle;
  logic signed [15:0]  joint2_angle;
  logic signed [15:0]  joint3_angle;
  logic signed [15:0]  joint4_angle;
  logic signed [15:0]  joint5_angle;
  logic signed [15:0]  joint6_angle;

  modport source (output valid, joint1_angle, joint2_angle, joint3_angle,
                  joint4_angle, joint5_angle, joint6_angle, input ready);
  modport sink   (input valid, joint1_angle, joint2_angle, joint3_angle,
                  joint4_angle, joint5_angle, joint6_angle, output ready);
endinterface

// ===== rtl/dhfk_out_if.sv =====
interface dhfk_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] rot_r0c0;
  logic signed [17:0] rot_r0c1;
  logic signed [17:0] rot_r0c2;
  logic signed [17:0] rot_r1c0;
  logic signed [17:0] rot_r1c1;
  logic signed [17:0] rot_r1c2;
  logic signed [17:0] rot_r2c0;
  logic signed [17:0] rot_r2c1;
  logic signed [17:0] rot_r2c2;
  logic signed [19:0] pos_x;
  logic signed [19:0] pos_y;
  logic signed [19:0] pos_z;

  modport source (output valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                  rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, pos_x, pos_y, pos_z,
                  input ready);
  modport sink   (input valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                  rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, pos_x, pos_y, pos_z,
                  output ready);
endinterface

// ===== rtl/dhfk_cordic.sv =====
module dhfk_cordic #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               en,
  input  dhfk_pkg::ang_t     ang,
  output dhfk_pkg::rot_ent_t co,
  output dhfk_pkg::rot_ent_t si
);

  localparam logic signed [32:0] X0 = 33'sd652032874;

  logic signed [32:0] x_r [STAGES+1];
  logic signed [32:0] y_r [STAGES+1];
  logic signed [32:0] z_r [STAGES+1];
  logic               n_r [STAGES+1];
  logic signed [16:0] fold;
  logic               fold_neg;
  logic signed [32:0] xr, yr;
  dhfk_pkg::rot_ent_t xs, ys;
  dhfk_pkg::rot_ent_t co_r, si_r;

  // fold angle into the right half plane, remember the sign flip
  always_comb begin
    fold     = 17'(ang);
    fold_neg = 1'b0;
    if (ang > 16'sd16384) begin
      fold     = 17'(ang) - 17'sd32768;
      fold_neg = 1'b1;
    end else if (ang < -16'sd16384) begin
      fold     = 17'(ang) + 17'sd32768;
      fold_neg = 1'b1;
    end
  end

  // binary angle times 65536 gives the angle in 2^-32 turn
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= X0;
      y_r[0] <= '0;
      z_r[0] <= {fold, 16'd0};
      n_r[0] <= fold_neg;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i+1] <= n_r[i];
        if (!z_r[i][32]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - dhfk_pkg::atan_val(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + dhfk_pkg::atan_val(i);
        end
      end
    end
  end

  // round Q2.30 to Q1.16, clamp, undo the fold
  always_comb begin
    xr = (x_r[STAGES] + 33'sd8192) >>> 14;
    yr = (y_r[STAGES] + 33'sd8192) >>> 14;
    xs = dhfk_pkg::sat_rot(40'(xr));
    ys = dhfk_pkg::sat_rot(40'(yr));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      co_r <= n_r[STAGES] ? -xs : xs;
      si_r <= n_r[STAGES] ? -ys : ys;
    end
  end

  assign co = co_r;
  assign si = si_r;

endmodule

// ===== rtl/dhfk_link.sv =====
module dhfk_link (
  input  logic               clk,
  input  logic               en,
  input  dhfk_pkg::twist_t   twist,
  input  dhfk_pkg::len_t     a_len,
  input  dhfk_pkg::len_t     d_len,
  input  dhfk_pkg::rot_ent_t co,
  input  dhfk_pkg::rot_ent_t si,
  input  dhfk_pkg::rot_ent_t rot_i [9],
  input  dhfk_pkg::acc_t     pos_i [3],
  output dhfk_pkg::rot_ent_t rot_o [9],
  output dhfk_pkg::acc_t     pos_o [3]
);

  logic signed [35:0] m0c_r [3];
  logic signed [35:0] m1s_r [3];
  logic signed [35:0] m1c_r [3];
  logic signed [35:0] m0s_r [3];
  logic signed [30:0] pd1_r [3];
  dhfk_pkg::rot_ent_t r2_r  [3];
  dhfk_pkg::acc_t     p1_r  [3];

  logic signed [36:0] sum_a [3];
  logic signed [36:0] sum_b [3];
  dhfk_pkg::acc_t     rnd_a [3];
  dhfk_pkg::acc_t     rnd_b [3];
  dhfk_pkg::acc_t     rnd_nb [3];
  dhfk_pkg::rot_ent_t rot_nxt [9];

  dhfk_pkg::rot_ent_t rot2_r [9];
  logic signed [36:0] a2_r  [3];
  logic signed [30:0] pd2_r [3];
  dhfk_pkg::acc_t     p2_r  [3];

  logic signed [49:0] pa    [3];
  logic signed [49:0] pa_rnd [3];
  dhfk_pkg::rot_ent_t rot3_r [9];
  dhfk_pkg::acc_t     p3_r  [3];

  // stage 1: row products with the joint rotation, length term along z
  for (genvar r = 0; r < 3; r++) begin : g_s1
    always_ff @(posedge clk) begin
      if (en) begin
        m0c_r[r] <= rot_i[3*r]   * co;
        m1s_r[r] <= rot_i[3*r+1] * si;
        m1c_r[r] <= rot_i[3*r+1] * co;
        m0s_r[r] <= rot_i[3*r]   * si;
        pd1_r[r] <= rot_i[3*r+2] * $signed({1'b0, d_len});
        r2_r[r]  <= rot_i[3*r+2];
        p1_r[r]  <= pos_i[r];
      end
    end
  end

  // stage 2: sum, round and clamp the new rotation row
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_a[r]  = 37'(m0c_r[r]) + 37'(m1s_r[r]);
      sum_b[r]  = 37'(m1c_r[r]) - 37'(m0s_r[r]);
      rnd_a[r]  = (40'(sum_a[r]) + 40'sd32768) >>> 16;
      rnd_b[r]  = (40'(sum_b[r]) + 40'sd32768) >>> 16;
      rnd_nb[r] = (-40'(sum_b[r]) + 40'sd32768) >>> 16;
      rot_nxt[3*r] = dhfk_pkg::sat_rot(rnd_a[r]);
      case (twist)
        dhfk_pkg::TW_POS90: begin
          rot_nxt[3*r+1] = r2_r[r];
          rot_nxt[3*r+2] = dhfk_pkg::sat_rot(rnd_nb[r]);
        end
        dhfk_pkg::TW_NEG90: begin
          rot_nxt[3*r+1] = -r2_r[r];
          rot_nxt[3*r+2] = dhfk_pkg::sat_rot(rnd_b[r]);
        end
        default: begin
          rot_nxt[3*r+1] = dhfk_pkg::sat_rot(rnd_b[r]);
          rot_nxt[3*r+2] = r2_r[r];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot2_r <= rot_nxt;
      a2_r   <= sum_a;
      pd2_r  <= pd1_r;
      p2_r   <= p1_r;
    end
  end

  // stage 3: scale the x-length term and advance the position
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      pa[r]     = a2_r[r] * $signed({1'b0, a_len});
      pa_rnd[r] = (pa[r] + 50'sd32768) >>> 16;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_s3
    always_ff @(posedge clk) begin
      if (en) begin
        p3_r[r] <= p2_r[r] + 40'(pd2_r[r]) + $signed(pa_rnd[r][39:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot3_r <= rot2_r;
    end
  end

  assign rot_o = rot3_r;
  assign pos_o = p3_r;

endmodule

// ===== rtl/dh_forward_kinematics_6axis_unit.sv =====
// Channel  | Dir | Word
// in_chan  | in  | six 16-bit signed joint angles (binary angle, pi/32768)
// out_chan | out | 3x3 rotation in Q1.16 (18-bit), tool x/y/z in 1/16 mm (20-bit)
// cfg_*    | in  | write enable, register index, 12-bit length in mm
//
// One word enters per cycle while the output is empty or taken; each word passes
// through the CORDIC sine/cosine pipeline plus three stages per joint link.
// rst_n is synchronous, active low; it clears valid bits and restores the
// power-on link lengths.
// All stages advance together when the output is empty or taken; a stall
// holds every stage, so no word is lost or repeated.
module dh_forward_kinematics_6axis_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  dhfk_in_if.sink                           in_chan,
  dhfk_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [dhfk_pkg::CfgIdxW-1:0]      cfg_idx,
  input  logic [dhfk_pkg::LenW-1:0]         cfg_data
);

  localparam int NJ  = dhfk_pkg::NumJoints;
  localparam int LAT = CORDIC_STAGES + 3 * NJ + 5;

  logic               en;
  logic [LAT-1:0]     v_r;
  dhfk_pkg::len_t     base_r, upper_r, fore_r, wrist_r, tool_r;
  dhfk_pkg::ang_t     ang_in [NJ];
  dhfk_pkg::ang_t     ang_dly [NJ];
  dhfk_pkg::rot_ent_t co_w [NJ];
  dhfk_pkg::rot_ent_t si_w [NJ];
  dhfk_pkg::rot_ent_t rot_w [NJ+1][9];
  dhfk_pkg::acc_t     pos_w [NJ+1][3];
  dhfk_pkg::rot_ent_t rot_e1_r [9];
  dhfk_pkg::rot_ent_t rot_e2_r [9];
  dhfk_pkg::rot_ent_t rot_o_r  [9];
  logic signed [30:0] pd_e1_r [3];
  dhfk_pkg::acc_t     p_e1_r  [3];
  dhfk_pkg::acc_t     p_e2_r  [3];
  dhfk_pkg::acc_t     q       [3];
  logic signed [dhfk_pkg::PosW-1:0] pos_nxt [3];
  logic signed [dhfk_pkg::PosW-1:0] pos_o_r [3];

  // advance the whole pipeline when the output word is empty or taken
  assign en            = !v_r[LAT-1] || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_chan.valid};
    end
  end

  // link length registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= 12'd330;
      upper_r <= 12'd400;
      fore_r  <= 12'd400;
      wrist_r <= 12'd100;
      tool_r  <= 12'd100;
    end else if (cfg_we) begin
      case (cfg_idx)
        dhfk_pkg::CFG_BASE_HEIGHT:      base_r  <= cfg_data;
        dhfk_pkg::CFG_UPPER_ARM_LENGTH: upper_r <= cfg_data;
        dhfk_pkg::CFG_FOREARM_OFFSET:   fore_r  <= cfg_data;
        dhfk_pkg::CFG_WRIST_OFFSET:     wrist_r <= cfg_data;
        dhfk_pkg::CFG_TOOL_LENGTH:      tool_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ang_in[0] = in_chan.joint1_angle;
  assign ang_in[1] = in_chan.joint2_angle;
  assign ang_in[2] = in_chan.joint3_angle;
  assign ang_in[3] = in_chan.joint4_angle;
  assign ang_in[4] = in_chan.joint5_angle;
  assign ang_in[5] = in_chan.joint6_angle;

  // delay each angle so its sine/cosine meets its link
  assign ang_dly[0] = ang_in[0];
  for (genvar k = 1; k < NJ; k++) begin : g_dly
    dhfk_pkg::ang_t line_r [3*k];
    always_ff @(posedge clk) begin
      if (en) begin
        line_r[0] <= ang_in[k];
        for (int i = 1; i < 3*k; i++) begin
          line_r[i] <= line_r[i-1];
        end
      end
    end
    assign ang_dly[k] = line_r[3*k-1];
  end

  for (genvar k = 0; k < NJ; k++) begin : g_cordic
    dhfk_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clk (clk),
      .en  (en),
      .ang (ang_dly[k]),
      .co  (co_w[k]),
      .si  (si_w[k])
    );
  end

  // chain starts at identity and the origin
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rot_w[0][i] = (i % 4 == 0) ? 18'sd65536 : 18'sd0;
    end
    for (int r = 0; r < 3; r++) begin
      pos_w[0][r] = '0;
    end
  end

  for (genvar k = 0; k < NJ; k++) begin : g_link
    dhfk_link u_link (
      .clk   (clk),
      .en    (en),
      .twist (dhfk_pkg::link_twist(k)),
      .a_len ((k == 2) ? upper_r : 12'd0),
      .d_len ((k == 0) ? base_r : (k == 3) ? fore_r : (k == 5) ? wrist_r : 12'd0),
      .co    (co_w[k]),
      .si    (si_w[k]),
      .rot_i (rot_w[k]),
      .pos_i (pos_w[k]),
      .rot_o (rot_w[k+1]),
      .pos_o (pos_w[k+1])
    );
  end

  // end effector: rotation unchanged, move along the tool z axis
  for (genvar r = 0; r < 3; r++) begin : g_tool
    always_ff @(posedge clk) begin
      if (en) begin
        pd_e1_r[r] <= rot_w[NJ][3*r+2] * $signed({1'b0, tool_r});
        p_e1_r[r]  <= pos_w[NJ][r];
        p_e2_r[r]  <= p_e1_r[r] + 40'(pd_e1_r[r]);
      end
    end
  end

  // round position to 1/16 mm and saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      q[r] = (p_e2_r[r] + 40'sd2048) >>> 12;
      if (q[r] > 40'sd524287) begin
        pos_nxt[r] = 20'sd524287;
      end else if (q[r] < -40'sd524288) begin
        pos_nxt[r] = -20'sd524288;
      end else begin
        pos_nxt[r] = q[r][dhfk_pkg::PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_e1_r <= rot_w[NJ];
      rot_e2_r <= rot_e1_r;
      rot_o_r  <= rot_e2_r;
      pos_o_r  <= pos_nxt;
    end
  end

  assign out_chan.valid    = v_r[LAT-1];
  assign out_chan.rot_r0c0 = rot_o_r[0];
  assign out_chan.rot_r0c1 = rot_o_r[1];
  assign out_chan.rot_r0c2 = rot_o_r[2];
  assign out_chan.rot_r1c0 = rot_o_r[3];
  assign out_chan.rot_r1c1 = rot_o_r[4];
  assign out_chan.rot_r1c2 = rot_o_r[5];
  assign out_chan.rot_r2c0 = rot_o_r[6];
  assign out_chan.rot_r2c1 = rot_o_r[7];
  assign out_chan.rot_r2c2 = rot_o_r[8];
  assign out_chan.pos_x    = pos_o_r[0];
  assign out_chan.pos_y    = pos_o_r[1];
  assign out_chan.pos_z    = pos_o_r[2];

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> v_r[0])
    else $error("accepted word did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("valid bits moved during a stall");

  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.rot_r0c0 <= 18'sd65536) &&
                       (out_chan.rot_r0c0 >= -18'sd65536) &&
                       (out_chan.rot_r2c2 <= 18'sd65536) &&
                       (out_chan.rot_r2c2 >= -18'sd65536))
    else $error("rotation entry out of range");
`endif

endmodule
